// ===== hdl/kat_pkg.sv =====
package kat_pkg;

   // table depth default
   localparam int CAPACITY_DEF = 32;

   // field widths
   localparam int CODE_W = 16;
   localparam int PRN_W  = 8;
   localparam int NUM_W  = 32;
   localparam int SUM_W  = 48;
   localparam int MARK_W = 16;

   // opcodes of an input item
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   // saturation limits of the sum
   localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

   typedef struct packed {
      logic                    opcode;
      logic [CODE_W-1:0]       company;
      logic [CODE_W-1:0]       branch;
      logic [CODE_W-1:0]       rec_kind;
      logic [PRN_W-1:0]        printer;
      logic [NUM_W-1:0]        item_key;
      logic [NUM_W-1:0]        place_key;
      logic [NUM_W-1:0]        proc_id;
      logic signed [SUM_W-1:0] amount;
      logic [MARK_W-1:0]       line_mark;
   } kat_req_type;

   typedef struct packed {
      logic [CODE_W-1:0]       out_company;
      logic [CODE_W-1:0]       out_branch;
      logic [CODE_W-1:0]       out_kind;
      logic [PRN_W-1:0]        out_printer;
      logic [NUM_W-1:0]        out_item_key;
      logic [NUM_W-1:0]        out_place_key;
      logic [NUM_W-1:0]        out_proc_id;
      logic signed [SUM_W-1:0] out_sum;
      logic [MARK_W-1:0]       out_line_mark;
      logic                    last_of_flush;
   } kat_rsp_type;

   typedef struct packed {
      logic [CODE_W-1:0] company;
      logic [CODE_W-1:0] branch;
      logic [CODE_W-1:0] kind;
      logic [PRN_W-1:0]  printer;
      logic [NUM_W-1:0]  item_key;
      logic [NUM_W-1:0]  place_key;
      logic [NUM_W-1:0]  proc_id;
   } kat_key_type;

   typedef struct packed {
      kat_key_type             key;
      logic signed [SUM_W-1:0] sum;
      logic [MARK_W-1:0]       line_mark;
   } kat_entry_type;

   // per-cell control from the sequencer
   typedef struct packed {
      logic match;   // compare the request key, cell is occupied
      logic update;  // merge the request if this cell hit
      logic shift;   // take the neighbor's entry
      logic load;    // store the request as a new entry
   } kat_cell_ctrl_type;

   // key part of a request item
   function automatic kat_key_type req_key(input kat_req_type r);
      kat_key_type k;
      k.company   = r.company;
      k.branch    = r.branch;
      k.kind      = r.rec_kind;
      k.printer   = r.printer;
      k.item_key  = r.item_key;
      k.place_key = r.place_key;
      k.proc_id   = r.proc_id;
      return k;
   endfunction

endpackage

// ===== hdl/kat_cell.sv =====
module kat_cell (
   input  logic                      clock,
   input  logic                      reset,
   input  kat_pkg::kat_cell_ctrl_type ctrl,
   input  kat_pkg::kat_req_type      req,
   input  kat_pkg::kat_entry_type    shift_in,
   output kat_pkg::kat_entry_type    entry,
   output logic                      hit
);
   import kat_pkg::*;

   kat_entry_type           entry_ff, entry_in;
   logic                    hit_ff, hit_in;
   logic signed [SUM_W:0]   sum_wide;
   logic signed [SUM_W-1:0] sum_sat;

   // key compare, registered for the update cycle
   assign hit_in = ctrl.match && (entry_ff.key == req_key(req));

   // saturating merge of the amount
   assign sum_wide = {entry_ff.sum[SUM_W-1], entry_ff.sum} + {req.amount[SUM_W-1], req.amount};

   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_sat = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
      end else begin
         sum_sat = sum_wide[SUM_W-1:0];
      end
   end

   // entry next value: load over shift over merge
   always_comb begin
      entry_in = entry_ff;
      priority if (ctrl.load) begin
         entry_in.key       = req_key(req);
         entry_in.sum       = req.amount;
         entry_in.line_mark = req.line_mark;
      end else if (ctrl.shift) begin
         entry_in = shift_in;
      end else if (ctrl.update && hit_ff) begin
         entry_in.sum = sum_sat;
         if (entry_ff.line_mark < req.line_mark) begin
            entry_in.line_mark = req.line_mark;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

// ===== hdl/keyed_accumulate_table_top.sv =====
// Group-by-key aggregation table built as a row of CAPACITY cells, one entry per cell.
// An add item compares its key against all occupied cells at once, then merges into the
// matching cell (saturating sum, larger line mark) or appends at the fill position; busy
// stays high through the match and update states. A flush item shifts the row toward
// cell 0 one entry per cycle and emits one result per cycle, oldest first, the last one
// flagged by last_of_flush; an empty table gives no result and busy stays low. An add
// with a new key to a full table flushes all CAPACITY entries first and then stores the
// record in cell 0. Each result is presented on rsp_item for exactly one cycle with
// rsp_valid high, registered from cell 0 as the shift moves it out; the receiver cannot
// stall the block and must take every result as it comes. Entry contents are not
// cleared at reset, only the fill count is, so no start-up pass is needed.
module keyed_accumulate_table_top #(
   parameter int CAPACITY = kat_pkg::CAPACITY_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  kat_pkg::kat_req_type req_item,
   output logic                 rsp_valid,
   output kat_pkg::kat_rsp_type rsp_item
);
   import kat_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_MATCH  = 4'b0010,
      ST_UPDATE = 4'b0100,
      ST_FLUSH  = 4'b1000
   } kat_state_type;

   kat_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              pend_ff, pend_in;
   kat_req_type       req_ff;
   logic              rsp_valid_ff;
   kat_rsp_type       rsp_item_ff;

   logic              accept;
   logic              any_hit;
   logic              do_append;
   logic              do_reload;
   logic [CAPACITY-1:0] hit;
   kat_entry_type     entry [CAPACITY];
   kat_cell_ctrl_type ctrl  [CAPACITY];

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign any_hit = |hit;

   // sequencer
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pend_in   = pend_ff;
      do_append = 1'b0;
      do_reload = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_item.opcode == OP_FLUSH) begin
                  pend_in = 1'b0;
                  if (count_ff != '0) begin
                     state_in = ST_FLUSH;
                  end
               end else begin
                  state_in = ST_MATCH;
               end
            end
         end
         ST_MATCH: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            priority if (any_hit) begin
               state_in = ST_IDLE;
            end else if (count_ff == CNT_W'(CAPACITY)) begin
               pend_in  = 1'b1;
               state_in = ST_FLUSH;
            end else begin
               do_append = 1'b1;
               count_in  = count_ff + CNT_W'(1);
               state_in  = ST_IDLE;
            end
         end
         ST_FLUSH: begin
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
               if (pend_ff) begin
                  do_reload = 1'b1;
                  count_in  = CNT_W'(1);
                  pend_in   = 1'b0;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= (state_ff == ST_FLUSH);
      end
   end

   // request and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_item;
      end
      rsp_item_ff.out_company   <= entry[0].key.company;
      rsp_item_ff.out_branch    <= entry[0].key.branch;
      rsp_item_ff.out_kind      <= entry[0].key.kind;
      rsp_item_ff.out_printer   <= entry[0].key.printer;
      rsp_item_ff.out_item_key  <= entry[0].key.item_key;
      rsp_item_ff.out_place_key <= entry[0].key.place_key;
      rsp_item_ff.out_proc_id   <= entry[0].key.proc_id;
      rsp_item_ff.out_sum       <= entry[0].sum;
      rsp_item_ff.out_line_mark <= entry[0].line_mark;
      rsp_item_ff.last_of_flush <= (count_ff == CNT_W'(1));
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   // row of cells, shifting toward cell 0 on flush
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      kat_entry_type next_entry;

      if (i == CAPACITY - 1) begin : g_tail
         always_comb begin
            next_entry.key       = req_key(req_ff);
            next_entry.sum       = req_ff.amount;
            next_entry.line_mark = req_ff.line_mark;
         end
      end else begin : g_body
         assign next_entry = entry[i+1];
      end

      always_comb begin
         ctrl[i].match  = (state_ff == ST_MATCH) && (count_ff > CNT_W'(i));
         ctrl[i].update = (state_ff == ST_UPDATE);
         ctrl[i].shift  = (state_ff == ST_FLUSH);
         ctrl[i].load   = (do_append && (count_ff == CNT_W'(i))) || (do_reload && (i == 0));
      end

      kat_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctrl     (ctrl[i]),
         .req      (req_ff),
         .shift_in (next_entry),
         .entry    (entry[i]),
         .hit      (hit[i])
      );
   end

   // keys in the table are unique, so at most one cell hits
   a_single_hit: assert property (@(posedge clock) disable iff (reset) $onehot0(hit))
      else $error("more than one cell matched the key");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("fill count beyond capacity");

   a_rsp_from_flush: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_FLUSH))
      else $error("result shown outside a flush");

   a_last_ends_flush: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last_of_flush) |=> !rsp_valid)
      else $error("result after the last item of a flush");

   a_hit_in_update: assert property (@(posedge clock) disable iff (reset)
      any_hit |-> (state_ff == ST_UPDATE))
      else $error("cell hit outside the update cycle");

endmodule

// ===== test/keyed_accumulate_table_top_test.sv =====
module keyed_accumulate_table_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import kat_pkg::*;

   localparam int TABLE_DEPTH = CAPACITY_DEF;
   localparam int POOL_SIZE   = 40;
   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   kat_req_type req_item = '0;
   logic        rsp_valid;
   kat_rsp_type rsp_item;

   // predicted table contents and the entries still to come out
   kat_entry_type table_entries [TABLE_DEPTH];
   int            table_fill = 0;
   kat_rsp_type   expected_entries [$];
   kat_key_type   key_pool [POOL_SIZE];
   int            mismatch_count = 0;
   int            cycle_count = 0;

   keyed_accumulate_table_top #(
      .CAPACITY(TABLE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_item(rsp_item)
   );

   always #10 clock = ~clock;

   task automatic report_error(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) begin
         report_error($sformatf("%s: got %h, expected %h", name, got, want));
      end
   endtask

   // every stored entry comes out oldest first, the table empties
   function automatic void emit_table_contents();
      kat_rsp_type r;
      for (int i = 0; i < table_fill; i++) begin
         r.out_company   = table_entries[i].key.company;
         r.out_branch    = table_entries[i].key.branch;
         r.out_kind      = table_entries[i].key.kind;
         r.out_printer   = table_entries[i].key.printer;
         r.out_item_key  = table_entries[i].key.item_key;
         r.out_place_key = table_entries[i].key.place_key;
         r.out_proc_id   = table_entries[i].key.proc_id;
         r.out_sum       = table_entries[i].sum;
         r.out_line_mark = table_entries[i].line_mark;
         r.last_of_flush = (i == table_fill - 1);
         expected_entries.push_back(r);
      end
      table_fill = 0;
   endfunction

   // table update for one accepted item
   function automatic void predict_table_step(input kat_req_type item);
      kat_key_type            k;
      logic signed [SUM_W:0]  wide;
      int                     hit;
      k = '{item.company, item.branch, item.rec_kind, item.printer,
            item.item_key, item.place_key, item.proc_id};
      hit = -1;
      if (item.opcode == OP_FLUSH) begin
         emit_table_contents();
      end else begin
         for (int i = 0; i < table_fill; i++) begin
            if (hit < 0 && table_entries[i].key == k) hit = i;
         end
         if (hit >= 0) begin
            // merge with saturation and larger line mark
            wide = {table_entries[hit].sum[SUM_W-1], table_entries[hit].sum}
                 + {item.amount[SUM_W-1], item.amount};
            if (wide[SUM_W] != wide[SUM_W-1]) begin
               table_entries[hit].sum = wide[SUM_W] ? SUM_MIN : SUM_MAX;
            end else begin
               table_entries[hit].sum = wide[SUM_W-1:0];
            end
            if (item.line_mark > table_entries[hit].line_mark) begin
               table_entries[hit].line_mark = item.line_mark;
            end
         end else begin
            // new key, a full table is flushed first
            if (table_fill >= TABLE_DEPTH) emit_table_contents();
            table_entries[table_fill] = '{k, item.amount, item.line_mark};
            table_fill++;
         end
      end
   endfunction

   function automatic kat_req_type add_item(input kat_key_type k,
                                            input logic signed [SUM_W-1:0] amt,
                                            input logic [MARK_W-1:0] mark);
      kat_req_type r;
      r.opcode    = OP_ADD;
      r.company   = k.company;
      r.branch    = k.branch;
      r.rec_kind  = k.kind;
      r.printer   = k.printer;
      r.item_key  = k.item_key;
      r.place_key = k.place_key;
      r.proc_id   = k.proc_id;
      r.amount    = amt;
      r.line_mark = mark;
      return r;
   endfunction

   function automatic kat_key_type random_key();
      kat_key_type k;
      for (int b = 0; b < $bits(k); b++) k[b] = 1'($urandom_range(1));
      return k;
   endfunction

   // amounts biased toward the saturation limits and small values
   function automatic logic signed [SUM_W-1:0] random_amount();
      int          pick;
      logic [63:0] raw;
      pick = $urandom_range(99);
      raw  = {$urandom, $urandom};
      if (pick < 10) return SUM_MAX;
      if (pick < 20) return SUM_MIN;
      if (pick < 45) return {{(SUM_W-16){raw[15]}}, raw[15:0]};
      return raw[SUM_W-1:0];
   endfunction

   function automatic kat_req_type flush_item();
      kat_req_type r;
      r = add_item(random_key(), random_amount(), MARK_W'($urandom));
      r.opcode = OP_FLUSH;
      return r;
   endfunction

   // mostly known keys so merges happen, some near misses, some fresh keys
   function automatic kat_key_type random_add_key();
      kat_key_type k;
      int          pick;
      pick = $urandom_range(99);
      k = key_pool[$urandom_range(POOL_SIZE-1)];
      if (pick >= 90) begin
         k = random_key();
      end else if (pick >= 75) begin
         k[$urandom_range($bits(k)-1)] ^= 1'b1;
      end
      return k;
   endfunction

   // one item, held until the block takes it
   task automatic send_item(input kat_req_type item);
      req_item <= item;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      predict_table_step(item);
   endtask

   task automatic idle_sender(input int pct);
      int gap;
      gap = 0;
      while (gap < 16 && $urandom_range(99) < pct) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_results();
      start <= 1'b0;
      while (expected_entries.size() != 0) @(posedge clock);
   endtask

   // flushing an empty table gives nothing
   task automatic test_empty_flush();
      send_item(flush_item());
      send_item(flush_item());
   endtask

   // each key field alone tells entries apart, merge keeps the larger mark
   task automatic test_key_fields();
      kat_key_type v;
      send_item(add_item('0, '0, '0));
      send_item(add_item('1, SUM_MAX, '1));
      for (int f = 0; f < 7; f++) begin
         v = '0;
         unique case (f)
            0: v.company   = '1;
            1: v.branch    = '1;
            2: v.kind      = '1;
            3: v.printer   = '1;
            4: v.item_key  = '1;
            5: v.place_key = '1;
            default: v.proc_id = '1;
         endcase
         send_item(add_item(v, SUM_W'(f + 1), MARK_W'(f)));
      end
      send_item(add_item('0, SUM_W'(-1), 16'd5));
      send_item(add_item('0, SUM_W'(7), 16'd3));
      send_item(flush_item());
   endtask

   // sums clamp at both ends of the range
   task automatic test_saturation();
      kat_key_type k;
      k = random_key();
      send_item(add_item(k, SUM_MAX, '1));
      send_item(add_item(k, SUM_W'(1), '0));
      send_item(add_item(k, SUM_MIN, 16'd1));
      send_item(add_item(k, SUM_MIN, 16'd2));
      send_item(add_item(k, SUM_W'(-1), 16'hFFFE));
      send_item(flush_item());
   endtask

   // a full table merges in place, a new key flushes it first
   task automatic test_full_table();
      kat_key_type base;
      kat_key_type k;
      base = random_key();
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         k = base;
         k.item_key = i;
         send_item(add_item(k, random_amount(), MARK_W'($urandom)));
         idle_sender(12);
      end
      k.item_key = TABLE_DEPTH / 2;
      send_item(add_item(k, random_amount(), MARK_W'($urandom)));
      k.item_key = '1;
      send_item(add_item(k, random_amount(), MARK_W'($urandom)));
      send_item(add_item(k, random_amount(), MARK_W'($urandom)));
      send_item(flush_item());
   endtask

   task automatic test_random_traffic(input int idle_pct, input int items,
                                      input int flush_pct, input bit pause_midway);
      for (int n = 0; n < items; n++) begin
         idle_sender(idle_pct);
         if (pause_midway && n == items / 2) begin
            send_item(flush_item());
            wait_for_results();
         end
         if ($urandom_range(99) < flush_pct) begin
            send_item(flush_item());
         end else begin
            send_item(add_item(random_add_key(), random_amount(), MARK_W'($urandom)));
         end
      end
   endtask

   // every strobed result against the oldest prediction
   always @(posedge clock) begin : check_results
      kat_rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_entries.size() == 0) begin
            report_error($sformatf("unexpected result %h", rsp_item));
         end else begin
            want = expected_entries.pop_front();
            check_field("company", 64'(rsp_item.out_company), 64'(want.out_company));
            check_field("branch", 64'(rsp_item.out_branch), 64'(want.out_branch));
            check_field("kind", 64'(rsp_item.out_kind), 64'(want.out_kind));
            check_field("printer", 64'(rsp_item.out_printer), 64'(want.out_printer));
            check_field("item_key", 64'(rsp_item.out_item_key), 64'(want.out_item_key));
            check_field("place_key", 64'(rsp_item.out_place_key),
                        64'(want.out_place_key));
            check_field("proc_id", 64'(rsp_item.out_proc_id), 64'(want.out_proc_id));
            check_field("sum", 64'(rsp_item.out_sum), 64'(want.out_sum));
            check_field("line_mark", 64'(rsp_item.out_line_mark),
                        64'(want.out_line_mark));
            check_field("last_of_flush", 64'(rsp_item.last_of_flush),
                        64'(want.last_of_flush));
         end
      end
   end

   // run limit
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("keyed_accumulate_table_top regression: fail");
      $finish;
   end

   initial begin
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_flush();
      test_key_fields();
      test_saturation();
      test_full_table();
      test_random_traffic(12, 20, 8, 1'b1);
      test_random_traffic(80, 15, 8, 1'b0);
      test_random_traffic(0, 15, 3, 1'b0);

      // drain what is left in the table
      send_item(flush_item());
      wait_for_results();
      repeat (TABLE_DEPTH + 8) @(posedge clock);
      if (mismatch_count == 0 && expected_entries.size() == 0) begin
         $display("keyed_accumulate_table_top regression: pass");
      end else begin
         $display("keyed_accumulate_table_top regression: fail");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hdl/kat_pkg.sv
hdl/kat_cell.sv
hdl/keyed_accumulate_table_top.sv
test/keyed_accumulate_table_top_test.sv
